// File: rtl/cfma_pkg.sv
package cfma_pkg;

   // Stream widths: request data holds rule_index, addr_high, addr_low, mask_high,
   // mask_low and deny_flag, padded to whole bytes.
   localparam int REQ_TDATA_W = 264;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 6;

   // Operation and family codes.
   localparam logic       OP_WRITE   = 1'b0;
   localparam logic       OP_CHECK   = 1'b1;
   localparam logic [1:0] FAM_V4     = 2'd0;
   localparam logic [1:0] FAM_V6     = 2'd1;
   localparam logic [1:0] FAM_LOCAL  = 2'd2;

   // Verdict codes.
   localparam logic [1:0] VERDICT_DECLINED  = 2'd0;
   localparam logic [1:0] VERDICT_ALLOWED   = 2'd1;
   localparam logic [1:0] VERDICT_FORBIDDEN = 2'd2;

   // Local socket policy codes.
   localparam logic [1:0] POLICY_ALLOW = 2'd1;
   localparam logic [1:0] POLICY_DENY  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_V4_COUNT     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_V6_COUNT     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOCAL_POLICY = 2'd2;

   // Upper word of the low half of an IPv4-mapped IPv6 address (::ffff:a.b.c.d).
   localparam logic [31:0] V4_MAPPED_TAG = 32'h0000_FFFF;

   // Which rule list an item is meant for.
   typedef enum logic [1:0] {
      ROUTE_V4,
      ROUTE_V6,
      ROUTE_FIXED
   } route_type;

   // One item as it travels down the row of rule cells.
   typedef struct packed {
      logic        valid;
      logic        write;
      route_type   route;
      logic [4:0]  rule_index;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [63:0] mask_high;
      logic [63:0] mask_low;
      logic        deny;
      logic        decided;
      logic [1:0]  verdict;
   } token_type;

endpackage

// File: rtl/cfma_cell.sv
module cfma_cell #(
   parameter int INDEX  = 0,
   parameter bit HAS_V4 = 1'b1,
   parameter bit HAS_V6 = 1'b1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               v4_en,
   input  logic               v6_en,
   input  cfma_pkg::token_type tok_in,
   output cfma_pkg::token_type tok_out
);
   import cfma_pkg::*;

   token_type tok_ff;
   token_type tok_in_next;
   logic      slot_hit;
   logic      is_write;
   logic      v4_hit;
   logic      v4_deny;
   logic      v6_hit;
   logic      v6_deny;

   // A write item updates this slot as it passes; a check item looks at the rule held here.
   assign slot_hit = (32'(tok_in.rule_index) == 32'(INDEX));
   assign is_write = tok_in.valid && tok_in.write && slot_hit && advance;

   generate
      if (HAS_V4) begin : g_v4
         logic [31:0] addr_ff;
         logic [31:0] mask_ff;
         logic        deny_ff;

         // IPv4 rule storage, written in item order.
         always_ff @(posedge clock) begin
            if (is_write && tok_in.route == ROUTE_V4) begin
               addr_ff <= tok_in.addr_low[31:0];
               mask_ff <= tok_in.mask_low[31:0];
               deny_ff <= tok_in.deny;
            end
         end

         assign v4_hit  = v4_en && ((tok_in.addr_low[31:0] & mask_ff) == addr_ff);
         assign v4_deny = deny_ff;
      end else begin : g_no_v4
         assign v4_hit  = 1'b0;
         assign v4_deny = 1'b0;
      end

      if (HAS_V6) begin : g_v6
         logic [63:0] addr_hi_ff;
         logic [63:0] addr_lo_ff;
         logic [63:0] mask_hi_ff;
         logic [63:0] mask_lo_ff;
         logic        deny_ff;

         // IPv6 rule storage, written in item order.
         always_ff @(posedge clock) begin
            if (is_write && tok_in.route == ROUTE_V6) begin
               addr_hi_ff <= tok_in.addr_high;
               addr_lo_ff <= tok_in.addr_low;
               mask_hi_ff <= tok_in.mask_high;
               mask_lo_ff <= tok_in.mask_low;
               deny_ff    <= tok_in.deny;
            end
         end

         assign v6_hit  = v6_en &&
                          ((tok_in.addr_high & mask_hi_ff) == addr_hi_ff) &&
                          ((tok_in.addr_low & mask_lo_ff) == addr_lo_ff);
         assign v6_deny = deny_ff;
      end else begin : g_no_v6
         assign v6_hit  = 1'b0;
         assign v6_deny = 1'b0;
      end
   endgenerate

   // The first matching rule along the row decides an undecided check.
   always_comb begin
      tok_in_next = tok_in;
      if (tok_in.valid && !tok_in.write && !tok_in.decided) begin
         if (tok_in.route == ROUTE_V4 && v4_hit) begin
            tok_in_next.decided = 1'b1;
            tok_in_next.verdict = v4_deny ? VERDICT_FORBIDDEN : VERDICT_ALLOWED;
         end else if (tok_in.route == ROUTE_V6 && v6_hit) begin
            tok_in_next.decided = 1'b1;
            tok_in_next.verdict = v6_deny ? VERDICT_FORBIDDEN : VERDICT_ALLOWED;
         end
      end
   end

   // Hand the item to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

// File: rtl/cidr_first_match_access_filter.sv
// An accepted item passes each rule cell's register stage and then the result register.
// Throughput: one item per cycle; the whole row of cells holds while a result waits unread.
// Rule writes travel the same row, so they take effect in item order and give no result.
// Reset (synchronous, active high) empties the row and clears the configuration registers
// and the result flag; rule contents are left as they are and are undefined until written.
module cidr_first_match_access_filter #(
   parameter int V4_RULES = 32,
   parameter int V6_RULES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // rule_index, addr_high, addr_low, mask_high, mask_low, deny_flag, zero pad
   input  logic [cfma_pkg::REQ_TDATA_W-1:0] req_tdata,
   // op, family
   input  logic [cfma_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // verdict, zero pad
   output logic [cfma_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic [cfma_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [cfma_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cfma_pkg::*;

   localparam int CELLS = (V4_RULES > V6_RULES) ? V4_RULES : V6_RULES;

   logic [5:0] v4_count_ff;
   logic [4:0] v6_count_ff;
   logic [1:0] policy_ff;
   logic       rsp_valid_ff;
   logic [1:0] verdict_ff;
   logic       advance;
   logic       req_op;
   logic [1:0] req_family;
   logic       mapped;
   logic [1:0] local_verdict;
   token_type  entry;
   token_type  tok [0:CELLS];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_count_ff <= '0;
         v6_count_ff <= '0;
         policy_ff   <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_V4_COUNT:     v4_count_ff <= csr_wdata;
            CSR_V6_COUNT:     v6_count_ff <= csr_wdata[4:0];
            CSR_LOCAL_POLICY: policy_ff   <= csr_wdata[1:0];
            default:          ;
         endcase
      end
   end

   // The row moves unless a result is waiting to be taken.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   assign req_op     = req_tuser[0];
   assign req_family = req_tuser[2:1];
   assign mapped     = (req_tdata[68:5] == 64'd0) && (req_tdata[132:101] == V4_MAPPED_TAG);

   always_comb begin
      case (policy_ff)
         POLICY_ALLOW: local_verdict = VERDICT_ALLOWED;
         POLICY_DENY:  local_verdict = VERDICT_FORBIDDEN;
         default:      local_verdict = VERDICT_DECLINED;
      endcase
   end

   // Build the item that enters the first cell and pick its rule list.
   always_comb begin
      entry            = '0;
      entry.valid      = req_tvalid;
      entry.write      = (req_op == OP_WRITE);
      entry.rule_index = req_tdata[4:0];
      entry.addr_high  = req_tdata[68:5];
      entry.addr_low   = req_tdata[132:69];
      entry.mask_high  = req_tdata[196:133];
      entry.mask_low   = req_tdata[260:197];
      entry.deny       = req_tdata[261];
      entry.decided    = 1'b0;
      entry.verdict    = VERDICT_DECLINED;
      case (req_family)
         FAM_V4: begin
            entry.route = ROUTE_V4;
         end
         FAM_V6: begin
            if (req_op == OP_CHECK && mapped && v4_count_ff != 6'd0) begin
               entry.route = ROUTE_V4;
            end else begin
               entry.route = ROUTE_V6;
            end
         end
         FAM_LOCAL: begin
            entry.route   = ROUTE_FIXED;
            entry.decided = 1'b1;
            entry.verdict = local_verdict;
         end
         default: begin
            entry.route   = ROUTE_FIXED;
            entry.decided = 1'b1;
            entry.verdict = VERDICT_DECLINED;
         end
      endcase
   end

   assign tok[0] = entry;

   // Row of rule cells; each cell holds one slot of every list deep enough to reach it.
   generate
      for (genvar i = 0; i < CELLS; i++) begin : g_cell
         logic v4_en;
         logic v6_en;

         assign v4_en = (32'(v4_count_ff) > 32'(i));
         assign v6_en = (32'(v6_count_ff) > 32'(i));

         cfma_cell #(
            .INDEX  (i),
            .HAS_V4 (i < V4_RULES),
            .HAS_V6 (i < V6_RULES)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .v4_en   (v4_en),
            .v6_en   (v6_en),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
         );
      end
   endgenerate

   // Result register: only check items give a result.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tok[CELLS].valid && !tok[CELLS].write;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         verdict_ff <= tok[CELLS].decided ? tok[CELLS].verdict : VERDICT_DECLINED;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 2){1'b0}}, verdict_ff};

`ifndef SYNTHESIS
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (verdict_ff != 2'd3))
      else $error("verdict code out of range");

   a_row_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(tok[CELLS]))
      else $error("last cell changed while the row was held");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (advance && tok[CELLS].valid && tok[CELLS].write) |=> !rsp_valid_ff)
      else $error("rule write produced a result");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import cfma_pkg::*;

   localparam int V4_DEPTH = 32;
   localparam int V6_DEPTH = 16;
   // Results pass through the whole row of cells before they come out; keep a margin.
   localparam int DRAIN_CYCLES = 48;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 238;
   localparam int MAX_REPORTS = 10;
   // Family code that names no rule list.
   localparam logic [1:0] FAM_UNUSED = 2'd3;
   // Local policy code that the block treats like no local rules.
   localparam logic [1:0] POLICY_RESERVED = 2'd3;

   // One request item, field by field.
   typedef struct packed {
      logic        op;
      logic [1:0]  family;
      logic [4:0]  rule_index;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [63:0] mask_high;
      logic [63:0] mask_low;
      logic        deny;
   } acl_request_type;

   // Mirror of the rule tables and registers, and the verdicts still owed by the block.
   class acl_verdict_board;
      logic [31:0] v4_addr [V4_DEPTH];
      logic [31:0] v4_mask [V4_DEPTH];
      logic        v4_deny [V4_DEPTH];
      logic [63:0] v6_addr_hi [V6_DEPTH];
      logic [63:0] v6_addr_lo [V6_DEPTH];
      logic [63:0] v6_mask_hi [V6_DEPTH];
      logic [63:0] v6_mask_lo [V6_DEPTH];
      logic        v6_deny [V6_DEPTH];
      logic [5:0]  v4_count;
      logic [4:0]  v6_count;
      logic [1:0]  local_mode;
      logic [1:0]  pending_verdicts [$];
      int          mismatches;
      int          checks_seen;
      int          writes_seen;
      int          verdict_tally [4];

      function new();
         v4_count = '0;
         v6_count = '0;
         local_mode = '0;
         mismatches = 0;
         checks_seen = 0;
         writes_seen = 0;
         verdict_tally = '{0, 0, 0, 0};
      endfunction

      function void set_register(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_V4_COUNT:     v4_count = value;
            CSR_V6_COUNT:     v6_count = value[4:0];
            CSR_LOCAL_POLICY: local_mode = value[1:0];
            default: ;
         endcase
      endfunction

      function logic [1:0] rule_verdict(logic deny);
         return deny ? VERDICT_FORBIDDEN : VERDICT_ALLOWED;
      endfunction

      // First IPv4 rule in use whose masked address matches decides.
      function logic [1:0] match_v4(logic [31:0] a);
         int n;
         int i;
         n = (v4_count > V4_DEPTH) ? V4_DEPTH : v4_count;
         for (i = 0; i < n; i++)
            if ((a & v4_mask[i]) == v4_addr[i]) return rule_verdict(v4_deny[i]);
         return VERDICT_DECLINED;
      endfunction

      function logic [1:0] match_v6(logic [63:0] hi, logic [63:0] lo);
         int n;
         int i;
         n = (v6_count > V6_DEPTH) ? V6_DEPTH : v6_count;
         for (i = 0; i < n; i++)
            if ((hi & v6_mask_hi[i]) == v6_addr_hi[i] && (lo & v6_mask_lo[i]) == v6_addr_lo[i])
               return rule_verdict(v6_deny[i]);
         return VERDICT_DECLINED;
      endfunction

      function logic [1:0] predict_verdict(acl_request_type r);
         logic mapped;
         mapped = (r.addr_high == 64'd0) && (r.addr_low[63:32] == V4_MAPPED_TAG);
         case (r.family)
            FAM_V4: return match_v4(r.addr_low[31:0]);
            FAM_V6: begin
               // A v4-mapped address goes to the IPv4 list only while it holds rules.
               if (mapped && v4_count != 0) return match_v4(r.addr_low[31:0]);
               return match_v6(r.addr_high, r.addr_low);
            end
            FAM_LOCAL: begin
               if (local_mode == POLICY_ALLOW) return VERDICT_ALLOWED;
               if (local_mode == POLICY_DENY) return VERDICT_FORBIDDEN;
               return VERDICT_DECLINED;
            end
            default: return VERDICT_DECLINED;
         endcase
      endfunction

      // Rule writes update the mirror in item order; checks queue their verdict.
      function void note_request(acl_request_type r);
         if (r.op == OP_WRITE) begin
            writes_seen++;
            if (r.family == FAM_V4) begin
               v4_addr[r.rule_index] = r.addr_low[31:0];
               v4_mask[r.rule_index] = r.mask_low[31:0];
               v4_deny[r.rule_index] = r.deny;
            end else if (r.family == FAM_V6 && r.rule_index < V6_DEPTH) begin
               v6_addr_hi[r.rule_index[3:0]] = r.addr_high;
               v6_addr_lo[r.rule_index[3:0]] = r.addr_low;
               v6_mask_hi[r.rule_index[3:0]] = r.mask_high;
               v6_mask_lo[r.rule_index[3:0]] = r.mask_low;
               v6_deny[r.rule_index[3:0]] = r.deny;
            end
         end else begin
            checks_seen++;
            pending_verdicts.push_back(predict_verdict(r));
         end
      endfunction

      function void note_failure(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("[%0t] verdict error: %s", $time, what);
      endfunction

      function void check_verdict(logic [RSP_TDATA_W-1:0] tdata);
         logic [1:0] want;
         if (pending_verdicts.size() == 0) begin
            note_failure($sformatf("verdict %0d arrived with no check outstanding",
                                   tdata[1:0]));
         end else begin
            want = pending_verdicts.pop_front();
            if (tdata[1:0] !== want)
               note_failure($sformatf("expected verdict %0d, got %0d", want, tdata[1:0]));
            else
               verdict_tally[want]++;
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // rule_index, addr_high, addr_low, mask_high, mask_low, deny_flag, zero pad
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // op, family
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // verdict, zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int req_gap_pct = 0;
   int rsp_gap_pct = 0;
   int settings_applied = 0;
   acl_verdict_board board = new();

   cidr_first_match_access_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #10_000_000;
      $display("Run timed out with %0d verdicts outstanding.", board.pending_verdicts.size());
      $display("tb_top: FAIL");
      $finish;
   end

   // Every accepted verdict is compared with the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_verdict(rsp_tdata);
   end

   // The result side stalls in random bursts while a phase asks for it.
   initial begin : rsp_pacing
      int stall;
      forever begin
         if ($urandom_range(0, 99) < rsp_gap_pct) begin
            stall = $urandom_range(1, 9);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Offers one item, with an optional idle burst first, and records it once accepted.
   task automatic send_request(acl_request_type r);
      int gap;
      if ($urandom_range(0, 99) < req_gap_pct) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r.deny, r.mask_low, r.mask_high, r.addr_low, r.addr_high,
                     r.rule_index};
      req_tuser  <= {r.family, r.op};
      do @(posedge clock); while (!req_tready);
      board.note_request(r);
   endtask

   task automatic write_register(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.set_register(idx, value);
   endtask

   // Registers change only once the block is empty, rule writes included.
   task automatic apply_settings(logic [5:0] v4n, logic [5:0] v6n, logic [5:0] mode);
      req_tvalid <= 1'b0;
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_register(CSR_V4_COUNT, v4n);
      write_register(CSR_V6_COUNT, v6n);
      write_register(CSR_LOCAL_POLICY, mode);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   function automatic acl_request_type rule_item(logic [1:0] family, logic [4:0] idx,
         logic [63:0] ahi, logic [63:0] alo, logic [63:0] mhi, logic [63:0] mlo, logic deny);
      acl_request_type r;
      r = '{OP_WRITE, family, idx, ahi, alo, mhi, mlo, deny};
      return r;
   endfunction

   // Fields a check does not use are left random.
   function automatic acl_request_type check_item(logic [1:0] family, logic [63:0] ahi,
         logic [63:0] alo);
      acl_request_type r;
      r = '{OP_CHECK, family, 5'($urandom), ahi, alo, {$urandom, $urandom},
            {$urandom, $urandom}, 1'($urandom)};
      return r;
   endfunction

   function automatic logic [127:0] prefix_mask(int len);
      return (len <= 0) ? 128'd0 : ~128'd0 << (128 - len);
   endfunction

   // Prefix lengths lean on the common boundaries, /16 and /24 among them.
   function automatic int pick_prefix(int full);
      case ($urandom_range(0, 7))
         0: return 0;
         1: return full;
         2: return 16;
         3: return 24;
         4: return full / 2;
         default: return $urandom_range(0, full);
      endcase
   endfunction

   // A rule write with a mostly well-formed prefix, or a check aimed mostly at a rule in use.
   function automatic acl_request_type random_request(bit force_write, int fill_slot);
      acl_request_type r;
      logic [127:0] m;
      int sel;
      int span;
      int slot;
      r = check_item(FAM_V4, {$urandom, $urandom}, {$urandom, $urandom});
      if (force_write || $urandom_range(0, 99) < 25) begin
         r.op = OP_WRITE;
         sel = $urandom_range(0, 19);
         if (fill_slot >= 0) begin
            r.family = (fill_slot < V4_DEPTH) ? FAM_V4 : FAM_V6;
            r.rule_index = 5'(fill_slot % V4_DEPTH);
         end else if (sel == 0) begin
            r.family = $urandom_range(0, 1) ? FAM_LOCAL : FAM_UNUSED;
         end else begin
            r.family = (sel < 10) ? FAM_V4 : FAM_V6;
            if (r.family == FAM_V6 && $urandom_range(0, 5) != 0) r.rule_index[4] = 1'b0;
         end
         if ($urandom_range(0, 4) != 0) begin
            if (r.family == FAM_V6) begin
               m = prefix_mask(pick_prefix(128));
               r.mask_high = m[127:64];
               r.mask_low  = m[63:0];
               r.addr_high &= m[127:64];
               r.addr_low  &= m[63:0];
            end else begin
               m = prefix_mask(96 + pick_prefix(32));
               r.mask_low[31:0] = m[31:0];
               r.addr_low[31:0] &= m[31:0];
            end
         end
         return r;
      end
      sel = $urandom_range(0, 19);
      r.family = (sel < 8) ? FAM_V4 : (sel < 16) ? FAM_V6 : (sel < 19) ? FAM_LOCAL : FAM_UNUSED;
      if (r.family == FAM_V6 && $urandom_range(0, 3) == 0) begin
         // v4-mapped form, ::ffff:a.b.c.d
         r.addr_high = 64'd0;
         r.addr_low[63:32] = V4_MAPPED_TAG;
      end
      if ($urandom_range(0, 9) < 7) begin
         if (r.family == FAM_V6 && r.addr_high != 64'd0) begin
            span = (board.v6_count > V6_DEPTH) ? V6_DEPTH : board.v6_count;
            slot = (span == 0) ? $urandom_range(0, V6_DEPTH - 1) : $urandom_range(0, span - 1);
            r.addr_high = board.v6_addr_hi[slot] | ({$urandom, $urandom} & ~board.v6_mask_hi[slot]);
            r.addr_low  = board.v6_addr_lo[slot] | ({$urandom, $urandom} & ~board.v6_mask_lo[slot]);
         end else begin
            span = (board.v4_count > V4_DEPTH) ? V4_DEPTH : board.v4_count;
            slot = (span == 0) ? $urandom_range(0, V4_DEPTH - 1) : $urandom_range(0, span - 1);
            r.addr_low[31:0] = board.v4_addr[slot] | ($urandom & ~board.v4_mask[slot]);
         end
      end
      return r;
   endfunction

   initial begin : stimulus
      int p;
      int k;
      int phase_v4 [PHASES];
      int phase_v6 [PHASES];
      int phase_mode [PHASES];
      int phase_gap [PHASES];
      phase_v4   = '{32, 63, 1, 0, 33, 8, 0, 32};
      phase_v6   = '{16, 31, 1, 16, 17, 4, 0, 0};
      phase_mode = '{1, 2, 3, 0, 1, 2, 0, 1};
      phase_gap  = '{30, 0, 50, 20, 40, 25, 35, 0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty lists and no local rules: everything is declined.
      send_request(check_item(FAM_V4, 64'd0, 64'd0));
      send_request(check_item(FAM_V6, '1, '1));
      send_request(check_item(FAM_LOCAL, 64'd0, 64'd0));
      send_request(check_item(FAM_UNUSED, '1, '1));

      // A few rules, with writes that must be ignored in between.
      send_request(rule_item(FAM_V4, 5'd0, '1, {32'hFFFF_FFFF, 32'h0A00_0000}, '1,
                             {32'hFFFF_FFFF, 32'hFF00_0000}, 1'b0));
      send_request(rule_item(FAM_V4, 5'd1, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1));
      send_request(rule_item(FAM_V4, 5'd31, 64'd0, 64'h0000_0000_C0A8_0000, 64'd0,
                             64'h0000_0000_FFFF_0000, 1'b0));
      send_request(rule_item(FAM_V6, 5'd0, 64'h2001_0DB8_0000_0000, 64'd0,
                             64'hFFFF_FFFF_0000_0000, 64'd0, 1'b1));
      send_request(rule_item(FAM_V6, 5'd31, '1, '1, '1, '1, 1'b1));
      send_request(rule_item(FAM_LOCAL, 5'd0, '1, '1, '1, '1, 1'b1));
      send_request(rule_item(FAM_UNUSED, 5'd1, '1, '1, '1, '1, 1'b1));
      send_request(rule_item(FAM_V6, 5'd15, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0));

      apply_settings(6'd2, 6'd1, 6'(POLICY_ALLOW));
      send_request(check_item(FAM_V4, 64'd0, {32'hFFFF_FFFF, 32'h0A01_0203}));
      send_request(check_item(FAM_V4, '1, 64'h0000_0000_0B00_0001));
      send_request(check_item(FAM_V4, 64'd0, '1));
      send_request(check_item(FAM_V6, 64'd0, {V4_MAPPED_TAG, 32'h0A09_0909}));
      send_request(check_item(FAM_V6, 64'h2001_0DB8_0000_0000, 64'd1));
      send_request(check_item(FAM_V6, '1, '1));
      send_request(check_item(FAM_LOCAL, '1, '1));
      send_request(check_item(FAM_UNUSED, 64'd0, 64'd0));

      // With no IPv4 rules a mapped address falls through to the IPv6 list.
      apply_settings(6'd0, 6'd1, 6'(POLICY_DENY));
      send_request(check_item(FAM_V6, 64'd0, {V4_MAPPED_TAG, 32'h0A00_0001}));
      send_request(check_item(FAM_LOCAL, 64'd0, 64'd0));
      send_request(check_item(FAM_V4, 64'd0, 64'h0000_0000_0A00_0001));

      apply_settings(6'd0, 6'd0, 6'(POLICY_RESERVED));
      send_request(check_item(FAM_LOCAL, 64'd0, 64'd0));

      // Fill every slot so that any rule count is safe from here on.
      req_gap_pct = 20;
      rsp_gap_pct = 20;
      for (k = 0; k < V4_DEPTH + V6_DEPTH; k++) send_request(random_request(1'b1, k));

      // Random phases over a spread of settings, saturated counts among them.
      for (p = 0; p < PHASES; p++) begin
         if (p == 6)
            apply_settings(6'($urandom_range(0, 63)), 6'($urandom_range(0, 31)),
                           6'($urandom_range(0, 3)));
         else
            apply_settings(6'(phase_v4[p]), 6'(phase_v6[p]), 6'(phase_mode[p]));
         req_gap_pct = phase_gap[p];
         rsp_gap_pct = (p == PHASES - 1) ? 0 : $urandom_range(0, 50);
         for (k = 0; k < PHASE_ITEMS; k++) send_request(random_request(1'b0, -1));
      end

      req_tvalid <= 1'b0;
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d address checks and %0d rule writes under %0d register settings.",
               board.checks_seen, board.writes_seen, settings_applied);
      $display("Verdicts matched: %0d allowed, %0d forbidden, %0d declined; %0d errors.",
               board.verdict_tally[VERDICT_ALLOWED], board.verdict_tally[VERDICT_FORBIDDEN],
               board.verdict_tally[VERDICT_DECLINED], board.mismatches);
      if (board.mismatches == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

// File: cidr_first_match_access_filter.f
rtl/cfma_pkg.sv
rtl/cfma_cell.sv
rtl/cidr_first_match_access_filter.sv
tb/tb_top.sv
